/* hdl/cfq_pkg.sv */
// Shared types and constants for the circular FIFO queue unit.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package cfq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W  = 2;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 5;
    localparam int ST_W   = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd10;

    localparam logic [CMD_W-1:0] CMD_ENQ        = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ        = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK_REAR  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // Outcome of one command, passed from the pointer logic to the datapath.
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] count;
        logic             is_empty;
        logic             is_full;
    } t_ctrl;

endpackage
`default_nettype wire

/* hdl/cfq_in_if.sv */
// Command channel of the circular FIFO queue unit: valid, ready and one command beat.
// Depends on cfq_pkg for field widths.
`default_nettype none
interface cfq_in_if;
    logic                             valid;
    logic                             ready;
    logic [cfq_pkg::CMD_W-1:0]        command;
    logic signed [cfq_pkg::WORD_W-1:0] push_data;

    modport source (output valid, output command, output push_data, input ready);
    modport sink   (input valid, input command, input push_data, output ready);
endinterface
`default_nettype wire

/* hdl/cfq_out_if.sv */
// Result channel of the circular FIFO queue unit: valid, ready and one result beat.
// Depends on cfq_pkg for field widths.
`default_nettype none
interface cfq_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [cfq_pkg::WORD_W-1:0] read_data;
    logic [cfq_pkg::ST_W-1:0]          status;
    logic [cfq_pkg::CNT_W-1:0]         occupancy;
    logic                              is_empty;
    logic                              is_full;

    modport source (output valid, output read_data, output status, output occupancy,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input read_data, input status, input occupancy,
                    input is_empty, input is_full, output ready);
endinterface
`default_nettype wire

/* hdl/cfq_cfg_if.sv */
// Configuration write channel of the circular FIFO queue unit (capacity register).
// Depends on cfq_pkg for the register width.
`default_nettype none
interface cfq_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [cfq_pkg::CNT_W-1:0] queue_capacity;

    modport source (output valid, output queue_capacity, input ready);
    modport sink   (input valid, input queue_capacity, output ready);
endinterface
`default_nettype wire

/* hdl/cfq_ram.sv */
// Storage of the circular FIFO queue: one write port, one registered read port.
// Depends on cfq_pkg only for the default parameter values.
`default_nettype none
module cfq_ram #(
    parameter int DEPTH      = cfq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cfq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_WIDTH-1:0]    i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [DATA_WIDTH-1:0]    o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The read data holds while no read is issued, so a stalled beat keeps its word.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* hdl/cfq_ctrl.sv */
// Head, tail, count and capacity registers of the circular FIFO queue.
// Decides each command's outcome and storage address; depends on cfq_pkg.
`default_nettype none
module cfq_ctrl #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [cfq_pkg::CNT_W-1:0]   i_cfg_data,
    input  wire logic                        i_accept,
    input  wire logic [cfq_pkg::CMD_W-1:0]   i_command,
    output logic      [$clog2(DEPTH)-1:0]    o_addr,
    output cfq_pkg::t_ctrl                   o_ctrl
);

    localparam int PW = $clog2(DEPTH);

    logic [cfq_pkg::CNT_W-1:0] r_cap;
    logic [PW-1:0]             r_head, n_head;
    logic [PW-1:0]             r_tail, n_tail;
    logic [cfq_pkg::CNT_W-1:0] r_count, n_count;
    logic [cfq_pkg::CNT_W-1:0] w_eff_cap;
    logic [PW-1:0]             w_head_inc, w_tail_inc, w_last;
    logic                      w_full_now, w_empty_now;

    // A capacity of zero acts as one, and one above the depth acts as the depth.
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = cfq_pkg::CNT_W'(1);
        end else if (32'(r_cap) > DEPTH) begin
            w_eff_cap = cfq_pkg::CNT_W'(DEPTH);
        end else begin
            w_eff_cap = r_cap;
        end
    end

    always_comb begin
        w_head_inc = (32'(r_head) + 1 >= 32'(w_eff_cap)) ? '0 : PW'(32'(r_head) + 1);
        w_tail_inc = (32'(r_tail) + 1 >= 32'(w_eff_cap)) ? '0 : PW'(32'(r_tail) + 1);
        w_last     = (r_tail == '0) ? PW'(32'(w_eff_cap) - 1) : PW'(32'(r_tail) - 1);
    end

    assign w_full_now  = (r_count >= w_eff_cap);
    assign w_empty_now = (r_count == '0);

    always_comb begin
        n_head          = r_head;
        n_tail          = r_tail;
        n_count         = r_count;
        o_addr          = r_head;
        o_ctrl.wr_en    = 1'b0;
        o_ctrl.rd_en    = 1'b0;
        o_ctrl.status   = cfq_pkg::ST_OK;
        case (i_command)
            cfq_pkg::CMD_ENQ: begin
                o_addr = r_tail;
                if (w_full_now) begin
                    o_ctrl.status = cfq_pkg::ST_FULL;
                end else begin
                    o_ctrl.wr_en = i_accept;
                    n_tail       = w_tail_inc;
                    n_count      = r_count + 1'b1;
                end
            end
            cfq_pkg::CMD_DEQ: begin
                if (w_empty_now) begin
                    o_ctrl.status = cfq_pkg::ST_EMPTY;
                end else begin
                    o_ctrl.rd_en = i_accept;
                    n_head       = w_head_inc;
                    n_count      = r_count - 1'b1;
                end
            end
            cfq_pkg::CMD_PEEK_FRONT: begin
                if (w_empty_now) begin
                    o_ctrl.status = cfq_pkg::ST_EMPTY;
                end else begin
                    o_ctrl.rd_en = i_accept;
                end
            end
            default: begin
                o_addr = w_last;
                if (w_empty_now) begin
                    o_ctrl.status = cfq_pkg::ST_EMPTY;
                end else begin
                    o_ctrl.rd_en = i_accept;
                end
            end
        endcase
        o_ctrl.count    = n_count;
        o_ctrl.is_empty = (n_count == '0);
        o_ctrl.is_full  = (n_count == w_eff_cap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= cfq_pkg::CAP_RESET;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cfg_we) begin
            // A capacity write empties the queue.
            r_cap   <= i_cfg_data;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

/* hdl/circular_fifo_queue_unit.sv */
// Top level of the circular FIFO queue unit: pointer logic, storage and result register.
// Depends on cfq_pkg, cfq_in_if, cfq_out_if, cfq_cfg_if, cfq_ctrl and cfq_ram.
//
//   channel   modport   beat carries
//   i_in      sink      command, push_data
//   o_out     source    read_data, status, occupancy, is_empty, is_full
//   i_cfg     sink      queue_capacity (always ready)
//
// One command is taken per cycle while a stalled result does not hold i_in.ready low; the
// storage read and the outcome are registered at the accepting edge, and the result
// register loads from them when the read stage advances.
// Synchronous active-low reset empties the queue and loads capacity 10; storage is
// not cleared. A stalled result holds the result register, then the read stage,
// and only then is i_in.ready dropped.
`default_nettype none
module circular_fifo_queue_unit #(
    parameter int DEPTH      = cfq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cfq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cfq_in_if.sink     i_in,
    cfq_out_if.source  o_out,
    cfq_cfg_if.sink    i_cfg
);

    localparam int PW = $clog2(DEPTH);

    logic                  w_in_acc, w_adv, w_cfg_we;
    logic [PW-1:0]         w_addr;
    cfq_pkg::t_ctrl        w_ctrl;
    logic [63:0]           w_push_ext, w_rd_ext;
    logic [DATA_WIDTH-1:0] w_rd_data;

    logic                        r_s1_valid;
    cfq_pkg::t_ctrl              r_s1_ctrl;
    logic                        r_out_valid;
    logic [cfq_pkg::WORD_W-1:0]  r_out_data;
    logic [cfq_pkg::ST_W-1:0]    r_out_status;
    logic [cfq_pkg::CNT_W-1:0]   r_out_count;
    logic                        r_out_empty, r_out_full;

    assign w_adv       = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || w_adv;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid;

    cfq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (w_cfg_we),
        .i_cfg_data (i_cfg.queue_capacity),
        .i_accept   (w_in_acc),
        .i_command  (i_in.command),
        .o_addr     (w_addr),
        .o_ctrl     (w_ctrl)
    );

    // Words are stored at DATA_WIDTH bits; the result takes the low 32 bits back.
    assign w_push_ext = {{32{i_in.push_data[cfq_pkg::WORD_W-1]}}, i_in.push_data};

    cfq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ctrl.wr_en),
        .i_wr_addr (w_addr),
        .i_wr_data (w_push_ext[DATA_WIDTH-1:0]),
        .i_rd_en   (w_ctrl.rd_en),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_ext = 64'(w_rd_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_ctrl <= w_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data   <= r_s1_ctrl.rd_en ? w_rd_ext[cfq_pkg::WORD_W-1:0] : '0;
            r_out_status <= r_s1_ctrl.status;
            r_out_count  <= r_s1_ctrl.count;
            r_out_empty  <= r_s1_ctrl.is_empty;
            r_out_full   <= r_s1_ctrl.is_full;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_data;
    assign o_out.status    = r_out_status;
    assign o_out.occupancy = r_out_count;
    assign o_out.is_empty  = r_out_empty;
    assign o_out.is_full   = r_out_full;

    // Capacity is at least one, so a result never reports empty and full together.
    a_empty_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_empty && r_out_full))
        else $error("result reports empty and full at once");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == cfq_pkg::ST_FULL) |-> r_out_full)
        else $error("full status on a queue that is not full");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == cfq_pkg::ST_EMPTY)
            |-> (r_out_empty && r_out_data == '0))
        else $error("empty status with data or on a queue that is not empty");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> (r_s1_valid && $stable(r_s1_ctrl)))
        else $error("read stage lost its beat while stalled");

endmodule
`default_nettype wire

/* test/cfq_queue_checker.sv */
`timescale 1ns / 1ps
// Result checker for the circular FIFO queue unit: watches the command, result and
// capacity channels, predicts every result beat and compares it field by field.
// Depends on cfq_pkg and the cfq_in_if, cfq_out_if and cfq_cfg_if interfaces.
module cfq_queue_checker #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cfq_in_if         i_cmd,
    cfq_out_if        i_res,
    cfq_cfg_if        i_cfg,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        logic [cfq_pkg::WORD_W-1:0] read_data;
        logic [cfq_pkg::ST_W-1:0]   status;
        logic [cfq_pkg::CNT_W-1:0]  occupancy;
        logic                       is_empty;
        logic                       is_full;
    } t_queue_result;

    logic [cfq_pkg::WORD_W-1:0] ring_words [DEPTH];
    logic [cfq_pkg::CNT_W-1:0]  capacity_reg;
    int                         head_ptr;
    int                         tail_ptr;
    int                         fill_level;
    t_queue_result              expected_results [$];

    // A register value of zero behaves as one entry, anything above the depth as the depth.
    function automatic int active_capacity();
        if (capacity_reg == 0) return 1;
        if (int'(capacity_reg) > DEPTH) return DEPTH;
        return int'(capacity_reg);
    endfunction

    function automatic int wrap_next(input int ptr, input int cap);
        return (ptr + 1 >= cap) ? 0 : ptr + 1;
    endfunction

    task automatic apply_command(input logic [cfq_pkg::CMD_W-1:0] cmd,
                                 input logic [cfq_pkg::WORD_W-1:0] word,
                                 output t_queue_result res);
        int cap;
        int slot;
        cap = active_capacity();
        res = '0;
        res.status = cfq_pkg::ST_OK;
        if (cmd == cfq_pkg::CMD_ENQ) begin
            if (fill_level >= cap) begin
                res.status = cfq_pkg::ST_FULL;
            end else begin
                ring_words[tail_ptr] = word;
                tail_ptr = wrap_next(tail_ptr, cap);
                fill_level++;
            end
        end else if (fill_level == 0) begin
            res.status = cfq_pkg::ST_EMPTY;
        end else begin
            case (cmd)
                cfq_pkg::CMD_DEQ: begin
                    res.read_data = ring_words[head_ptr];
                    head_ptr = wrap_next(head_ptr, cap);
                    fill_level--;
                end
                cfq_pkg::CMD_PEEK_FRONT: begin
                    res.read_data = ring_words[head_ptr];
                end
                default: begin
                    // The newest entry sits just behind the tail, which may have wrapped.
                    slot = (tail_ptr == 0) ? cap - 1 : tail_ptr - 1;
                    res.read_data = ring_words[slot];
                end
            endcase
        end
        res.occupancy = cfq_pkg::CNT_W'(fill_level);
        res.is_empty  = (fill_level == 0);
        res.is_full   = (fill_level == cap);
    endtask

    function automatic int compare_result(input t_queue_result want, input t_queue_result got);
        int bad;
        bad = 0;
        if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0h, actual %0h", want.read_data, got.read_data);
            bad++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            bad++;
        end
        if (got.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
            bad++;
        end
        if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
            bad++;
        end
        if (got.is_full !== want.is_full) begin
            $error("is_full: expected %0d, actual %0d", want.is_full, got.is_full);
            bad++;
        end
        return bad;
    endfunction

    always @(posedge i_clk) begin
        t_queue_result got;
        t_queue_result want;
        int fails;
        fails = o_fail_count;
        if (!i_rst_n) begin
            capacity_reg = cfq_pkg::CAP_RESET;
            head_ptr     = 0;
            tail_ptr     = 0;
            fill_level   = 0;
            expected_results.delete();
            fails = 0;
        end else begin
            // A result beat can never belong to a command taken at the same edge,
            // so results are checked before new commands are predicted.
            if (i_res.valid && i_res.ready) begin
                got.read_data = i_res.read_data;
                got.status    = i_res.status;
                got.occupancy = i_res.occupancy;
                got.is_empty  = i_res.is_empty;
                got.is_full   = i_res.is_full;
                if (expected_results.size() == 0) begin
                    $error("result beat arrived with no command outstanding");
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    fails += compare_result(want, got);
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                capacity_reg = i_cfg.queue_capacity;
                head_ptr     = 0;
                tail_ptr     = 0;
                fill_level   = 0;
            end
            if (i_cmd.valid && i_cmd.ready) begin
                apply_command(i_cmd.command, i_cmd.push_data, want);
                expected_results.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

/* test/circular_fifo_queue_unit_tb.sv */
`timescale 1ns / 1ps
// Top of the circular FIFO queue unit testbench: clock, reset, command and capacity
// stimulus, result back-pressure and the verdict. Depends on cfq_pkg, the channel
// interfaces, the unit itself and cfq_queue_checker.
module circular_fifo_queue_unit_tb;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_ITEMS = 750;
    localparam int PHASES       = 10;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_BURSTY} t_ready_mode;
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_cmd_mix;

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count;
    int          pending_count;
    int          beats_sent;
    int          settings_used;
    int          burst_left;
    t_ready_mode ready_mode;

    cfq_in_if  cmd_ch ();
    cfq_out_if res_ch ();
    cfq_cfg_if cfg_ch ();

    circular_fifo_queue_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    cfq_queue_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result back-pressure: runs of ready or stall whose shape depends on the phase.
    initial begin
        int   run_left;
        logic level;
        run_left = 0;
        level = 1'b1;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (run_left == 0) begin
                case (ready_mode)
                    READY_ALWAYS: begin
                        level = 1'b1;
                        run_left = 16;
                    end
                    READY_RANDOM: begin
                        level = ($urandom_range(3, 0) != 0);
                        run_left = 1;
                    end
                    default: begin
                        level = !level;
                        run_left = level ? $urandom_range(12, 1) : $urandom_range(10, 1);
                    end
                endcase
            end
            run_left--;
            res_ch.ready <= level;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $error("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // One command beat; valid stays high into the next beat unless a gap is drawn.
    task automatic send_command(input logic [cfq_pkg::CMD_W-1:0] cmd,
                                input logic [cfq_pkg::WORD_W-1:0] word);
        int gap;
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= cmd;
        cmd_ch.push_data <= word;
        do @(posedge i_clk); while (!cmd_ch.ready);
        beats_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 30)
                                                    : $urandom_range(12, 0);
            gap = ($urandom_range(4, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                cmd_ch.valid     <= 1'b0;
                cmd_ch.command   <= cfq_pkg::CMD_W'($urandom());
                cmd_ch.push_data <= $urandom();
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [cfq_pkg::CNT_W-1:0] cap);
        wait_idle();
        cfg_ch.valid          <= 1'b1;
        cfg_ch.queue_capacity <= cap;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [cfq_pkg::WORD_W-1:0] pick_word();
        if ($urandom_range(9, 0) != 0) return $urandom();
        case ($urandom_range(3, 0))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Epochs that lean toward filling or draining drive the queue to both ends and
    // make the pointers wrap; the even mix adds scattered errors and peeks.
    task automatic run_random(input int count);
        int                        epoch_left;
        int                        pick;
        t_cmd_mix                  mix;
        logic [cfq_pkg::CMD_W-1:0] cmd;
        epoch_left = 0;
        mix = MIX_EVEN;
        for (int n = 0; n < count; n++) begin
            if (epoch_left == 0) begin
                mix = t_cmd_mix'($urandom_range(2, 0));
                epoch_left = $urandom_range(30, 4);
            end
            epoch_left--;
            pick = $urandom_range(99, 0);
            case (mix)
                MIX_FILL:  cmd = (pick < 70) ? cfq_pkg::CMD_ENQ :
                                 (pick < 85) ? cfq_pkg::CMD_DEQ : cfq_pkg::CMD_PEEK_FRONT;
                MIX_DRAIN: cmd = (pick < 20) ? cfq_pkg::CMD_ENQ :
                                 (pick < 75) ? cfq_pkg::CMD_DEQ : cfq_pkg::CMD_PEEK_REAR;
                default:   cmd = (pick < 40) ? cfq_pkg::CMD_ENQ :
                                 (pick < 70) ? cfq_pkg::CMD_DEQ :
                                 (pick < 85) ? cfq_pkg::CMD_PEEK_FRONT : cfq_pkg::CMD_PEEK_REAR;
            endcase
            send_command(cmd, pick_word());
        end
    endtask

    initial begin
        logic [cfq_pkg::CNT_W-1:0] cap;
        cmd_ch.valid          <= 1'b0;
        cmd_ch.command        <= cfq_pkg::CMD_ENQ;
        cmd_ch.push_data      <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.queue_capacity <= '0;
        i_rst_n               <= 1'b0;
        ready_mode            <= READY_ALWAYS;
        beats_sent    = 0;
        settings_used = 0;
        burst_left    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset capacity, untouched register.
        send_command(cfq_pkg::CMD_PEEK_REAR, 32'h0000_0000);
        send_command(cfq_pkg::CMD_ENQ, 32'h7FFF_FFFF);
        send_command(cfq_pkg::CMD_PEEK_REAR, 32'h0000_0000);
        send_command(cfq_pkg::CMD_DEQ, 32'hFFFF_FFFF);

        // Small queue: reads on empty, fill to full, refused enqueue, peek of the
        // newest entry right after the tail has wrapped, then drain past empty.
        write_capacity(5'd3);
        send_command(cfq_pkg::CMD_DEQ, 32'h0000_0000);
        send_command(cfq_pkg::CMD_PEEK_FRONT, 32'h0000_0000);
        send_command(cfq_pkg::CMD_PEEK_REAR, 32'h0000_0000);
        send_command(cfq_pkg::CMD_ENQ, 32'h8000_0000);
        send_command(cfq_pkg::CMD_ENQ, 32'hFFFF_FFFF);
        send_command(cfq_pkg::CMD_ENQ, 32'h0000_0000);
        send_command(cfq_pkg::CMD_PEEK_REAR, 32'h1234_5678);
        send_command(cfq_pkg::CMD_PEEK_FRONT, 32'h1234_5678);
        send_command(cfq_pkg::CMD_ENQ, 32'h7FFF_FFFF);
        send_command(cfq_pkg::CMD_DEQ, 32'h0000_0000);
        send_command(cfq_pkg::CMD_ENQ, 32'h5A5A_A5A5);
        send_command(cfq_pkg::CMD_PEEK_REAR, 32'h0000_0000);
        send_command(cfq_pkg::CMD_DEQ, 32'h0000_0000);
        send_command(cfq_pkg::CMD_DEQ, 32'h0000_0000);
        send_command(cfq_pkg::CMD_DEQ, 32'h0000_0000);
        send_command(cfq_pkg::CMD_DEQ, 32'h0000_0000);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       cap = 5'd1;
                1:       cap = 5'd16;
                2:       cap = 5'd0;
                3:       cap = 5'd31;
                4:       cap = 5'd17;
                5, 6, 7: cap = cfq_pkg::CNT_W'($urandom_range(15, 2));
                default: cap = cfq_pkg::CNT_W'($urandom_range(31, 0));
            endcase
            write_capacity(cap);
            ready_mode <= t_ready_mode'(p % 3);
            run_random(RANDOM_ITEMS / PHASES);
        end

        wait_idle();
        $display("Covered %0d command beats over %0d capacity writes, including zero, one,",
                 beats_sent, settings_used);
        $display("sixteen and oversized values, with sender gaps and result back-pressure.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/cfq_pkg.sv
hdl/cfq_in_if.sv
hdl/cfq_out_if.sv
hdl/cfq_cfg_if.sv
hdl/cfq_ram.sv
hdl/cfq_ctrl.sv
hdl/circular_fifo_queue_unit.sv
test/cfq_queue_checker.sv
test/circular_fifo_queue_unit_tb.sv
